>>> hw/rtl/bre_pkg.sv
// Shared constants, codes and the entry word layout of the residency evictor.
package bre_pkg;
   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int LAYER_W = 6;
   localparam int BYTE_W = 40;
   localparam int CNT_W = 32;
   localparam int PRIO_W = 16;
   localparam int EVCNT_W = 6;
   localparam logic [EVCNT_W-1:0] MAX_EVICTS = 6'd32;
   localparam logic [BYTE_W-1:0] DEFAULT_BUDGET = 40'd1073741824;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};
   localparam logic [LAYER_W-1:0] MAX_LIVE = LAYER_W'(MAX_ENTRIES);

   localparam logic [2:0] CMD_LOAD = 3'd0;
   localparam logic [2:0] CMD_UNLOAD = 3'd1;
   localparam logic [2:0] CMD_BUDGET = 3'd2;
   localparam logic [2:0] CMD_DEP = 3'd3;
   localparam logic [2:0] CMD_PRIO = 3'd4;
   localparam logic [2:0] CMD_SIZE = 3'd5;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_INDEX = 3'd1;
   localparam logic [2:0] ST_NO_ROOM = 3'd2;
   localparam logic [2:0] ST_DEPS = 3'd3;
   localparam logic [2:0] ST_BAD_ARG = 3'd4;

   localparam logic [1:0] REG_STRATEGY = 2'd0;
   localparam logic [1:0] REG_UNLOAD_EN = 2'd1;
   localparam logic [1:0] REG_DEP_TRACK = 2'd2;
   localparam logic [1:0] REG_LAYERS = 2'd3;

   localparam logic [1:0] STRAT_RECENT = 2'd0;
   localparam logic [1:0] STRAT_USED = 2'd1;
   localparam logic [1:0] STRAT_PRIO = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]      size;
      logic [CNT_W-1:0]       stamp;
      logic [CNT_W-1:0]       count;
      logic [PRIO_W-1:0]      prio;
      logic [MAX_ENTRIES-1:0] deps;
   } entry_type;

   localparam int WORD_W = $bits(entry_type);
endpackage

>>> hw/rtl/budgeted_residency_evictor.sv
// Top level: residency tracker with byte budget and eviction sequencer.
// Each eviction adds one scan of the live entries, an eviction report and
// a new budget check; up to 32 evictions per command.
// One command is in work at a time; the entry memory read port sets the pace.
// Reset: synchronous; entries read as zero until first written.
module budgeted_residency_evictor import bre_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_cmd,
   input  logic [LAYER_W-1:0]       req_layer,
   input  logic [LAYER_W-1:0]       req_other_layer,
   input  logic [BYTE_W-1:0]        req_value,
   input  logic signed [PRIO_W-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_kind,
   output logic [LAYER_W-1:0]       rsp_entry,
   output logic [2:0]               rsp_status,
   output logic [BYTE_W-1:0]        rsp_used_bytes,
   output logic [BYTE_W-1:0]        rsp_peak_bytes,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [5:0]               csr_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_EVICT = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [BYTE_W-1:0] value_ff, value_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [2:0] st_ff, st_in;
   logic [EVCNT_W-1:0] cnt_ff, cnt_in;
   entry_type tgt_ff, tgt_in;
   logic [LAYER_W-1:0] sidx_ff, sidx_in;
   logic [LAYER_W-1:0] pidx_ff, pidx_in;
   logic pv_ff, pv_in;
   logic found_ff, found_in;
   logic [LAYER_W-1:0] best_idx_ff, best_idx_in;
   logic [CNT_W-1:0] best_stamp_ff, best_stamp_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [BYTE_W-1:0] best_size_ff, best_size_in;
   logic [MAX_ENTRIES-1:0] res_ff, res_in;
   logic [MAX_ENTRIES-1:0] wv_ff, wv_in;
   logic rdv_ff;
   logic [1:0] strat_ff, strat_in;
   logic unl_ff, unl_in;
   logic dt_ff, dt_in;
   logic [5:0] layers_ff, layers_in;
   logic [BYTE_W-1:0] budget_ff, budget_in;
   logic [BYTE_W-1:0] used_ff, used_in;
   logic [BYTE_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0] stampc_ff, stampc_in;
   logic rv_ff, rv_in;
   logic rkind_ff, rkind_in;
   logic [LAYER_W-1:0] rentry_ff, rentry_in;
   logic [2:0] rst_ff, rst_in;
   logic [BYTE_W-1:0] rused_ff, rused_in;
   logic [BYTE_W-1:0] rpeak_ff, rpeak_in;
   logic rlast_ff, rlast_in;
   // the dependency write goes to the entry read for it, kept in other_ff
   logic [LAYER_W-1:0] other_ff;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_word, rd_word, rdw;
   logic [LAYER_W-1:0] live;
   logic out_free;
   logic [CNT_W-1:0] stamp_next;
   logic [BYTE_W:0] load_sum;
   logic [BYTE_W-1:0] load_used;
   logic req_ok, other_ok;
   logic eligible, better;

   bre_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_word),
      .rd_addr(rd_addr), .rd_data(rd_word)
   );

   function automatic entry_type touched(entry_type w, logic [CNT_W-1:0] s);
      entry_type r;
      r = w;
      r.stamp = s;
      r.count = (w.count == CNT_MAX) ? CNT_MAX : w.count + 1'b1;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] sub_floor(logic [BYTE_W-1:0] a,
                                                   logic [BYTE_W-1:0] b);
      return (a >= b) ? a - b : '0;
   endfunction

   assign live = (layers_ff < MAX_LIVE) ? layers_ff : MAX_LIVE;
   assign rdw = rdv_ff ? rd_word : '0;
   assign out_free = !rv_ff || rsp_ready;
   assign stamp_next = (stampc_ff == CNT_MAX) ? CNT_MAX : stampc_ff + 1'b1;
   assign load_sum = {1'b0, used_ff} + {1'b0, tgt_ff.size};
   assign load_used = load_sum[BYTE_W] ? BYTE_MAX : load_sum[BYTE_W-1:0];
   assign req_ok = req_layer < live;
   assign other_ok = req_other_layer < live;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_kind = rkind_ff;
   assign rsp_entry = rentry_ff;
   assign rsp_status = rst_ff;
   assign rsp_used_bytes = rused_ff;
   assign rsp_peak_bytes = rpeak_ff;
   assign rsp_last = rlast_ff;

   always_comb begin
      rd_addr = '0;
      if (state_ff == S_IDLE) begin
         rd_addr = (req_cmd == CMD_DEP) ? req_other_layer[IDX_W-1:0]
                                        : req_layer[IDX_W-1:0];
      end else if (state_ff == S_SCAN) begin
         rd_addr = sidx_ff[IDX_W-1:0];
      end
   end

   // candidate test for the entry whose data is returning this cycle
   always_comb begin
      eligible = res_ff[pidx_ff[IDX_W-1:0]] &&
                 !(dt_ff && ((rdw.deps & res_ff) != '0));
      better = 1'b0;
      if (cmd_ff == CMD_BUDGET) begin
         better = eligible && (rdw.size > best_size_ff);
      end else if (eligible && (pidx_ff != layer_ff)) begin
         if (!found_ff) begin
            better = 1'b1;
         end else begin
            case (strat_ff)
               STRAT_RECENT: better = rdw.stamp < best_stamp_ff;
               STRAT_USED: better = rdw.count < best_cnt_ff;
               STRAT_PRIO: better = $signed(rdw.prio) < $signed(best_prio_ff);
               default: better = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      layer_in = layer_ff;
      value_in = value_ff;
      prio_in = prio_ff;
      st_in = st_ff;
      cnt_in = cnt_ff;
      tgt_in = tgt_ff;
      sidx_in = sidx_ff;
      pidx_in = pidx_ff;
      pv_in = pv_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_cnt_in = best_cnt_ff;
      best_prio_in = best_prio_ff;
      best_size_in = best_size_ff;
      res_in = res_ff;
      wv_in = wv_ff;
      strat_in = strat_ff;
      unl_in = unl_ff;
      dt_in = dt_ff;
      layers_in = layers_ff;
      budget_in = budget_ff;
      used_in = used_ff;
      peak_in = peak_ff;
      stampc_in = stampc_ff;
      rv_in = rv_ff && !rsp_ready;
      rkind_in = rkind_ff;
      rentry_in = rentry_ff;
      rst_in = rst_ff;
      rused_in = rused_ff;
      rpeak_in = rpeak_ff;
      rlast_in = rlast_ff;
      wr_en = 1'b0;
      wr_addr = layer_ff[IDX_W-1:0];
      wr_word = rdw;

      if (csr_valid) begin
         case (csr_index)
            REG_STRATEGY: strat_in = csr_data[1:0];
            REG_UNLOAD_EN: unl_in = csr_data[0];
            REG_DEP_TRACK: dt_in = csr_data[0];
            REG_LAYERS: layers_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               layer_in = req_layer;
               value_in = req_value;
               prio_in = req_priority_req;
               st_in = ST_OK;
               cnt_in = '0;
               state_in = S_FINAL;
               case (req_cmd)
                  CMD_LOAD, CMD_UNLOAD, CMD_PRIO: begin
                     if (req_ok) state_in = S_RD;
                     else st_in = ST_BAD_INDEX;
                  end
                  CMD_SIZE: begin
                     if (!req_ok) st_in = ST_BAD_INDEX;
                     else if (res_ff[req_layer[IDX_W-1:0]]) st_in = ST_BAD_ARG;
                     else state_in = S_RD;
                  end
                  CMD_DEP: begin
                     if (!req_ok || !other_ok) st_in = ST_BAD_INDEX;
                     else if (req_layer == req_other_layer) st_in = ST_BAD_ARG;
                     else state_in = S_RD;
                  end
                  CMD_BUDGET: begin
                     if (req_value == '0) st_in = ST_BAD_ARG;
                     else state_in = S_CHECK;
                  end
                  default: st_in = ST_BAD_ARG;
               endcase
               // for a dependency command, clear the deps field of the held target word
               if (req_cmd == CMD_DEP) begin
                  tgt_in.deps = '0;
               end
            end
         end
         S_RD: begin
            state_in = S_FINAL;
            case (cmd_ff)
               CMD_LOAD: begin
                  if (res_ff[layer_ff[IDX_W-1:0]]) begin
                     stampc_in = stamp_next;
                     wr_en = 1'b1;
                     wr_word = touched(rdw, stamp_next);
                  end else begin
                     tgt_in = rdw;
                     state_in = S_CHECK;
                  end
               end
               CMD_UNLOAD: begin
                  if (res_ff[layer_ff[IDX_W-1:0]]) begin
                     if (dt_ff && ((rdw.deps & res_ff) != '0)) begin
                        st_in = ST_DEPS;
                     end else begin
                        res_in[layer_ff[IDX_W-1:0]] = 1'b0;
                        used_in = sub_floor(used_ff, rdw.size);
                     end
                  end
               end
               CMD_DEP: begin
                  wr_en = 1'b1;
                  wr_addr = other_ff[IDX_W-1:0];
                  wr_word.deps = rdw.deps | (MAX_ENTRIES'(1) << layer_ff[IDX_W-1:0]);
               end
               CMD_PRIO: begin
                  wr_en = 1'b1;
                  wr_word.prio = prio_ff;
               end
               default: begin
                  wr_en = 1'b1;
                  wr_word.size = value_ff;
               end
            endcase
         end
         S_CHECK: begin
            sidx_in = '0;
            pv_in = 1'b0;
            found_in = 1'b0;
            best_size_in = '0;
            if (cmd_ff == CMD_BUDGET) begin
               if (used_ff <= value_ff) begin
                  budget_in = value_ff;
                  state_in = S_FINAL;
               end else if (cnt_ff == MAX_EVICTS) begin
                  st_in = ST_NO_ROOM;
                  state_in = S_FINAL;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (!unl_ff || ({1'b0, budget_ff} >= load_sum)) begin
               // commit the load
               res_in[layer_ff[IDX_W-1:0]] = 1'b1;
               used_in = load_used;
               if (load_used > peak_ff) peak_in = load_used;
               stampc_in = stamp_next;
               wr_en = 1'b1;
               wr_word = touched(tgt_ff, stamp_next);
               state_in = S_FINAL;
            end else if (cnt_ff == MAX_EVICTS) begin
               st_in = ST_NO_ROOM;
               state_in = S_FINAL;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sidx_ff < live) begin
               sidx_in = sidx_ff + 1'b1;
               pidx_in = sidx_ff;
               pv_in = 1'b1;
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff && better) begin
               found_in = 1'b1;
               best_idx_in = pidx_ff;
               best_stamp_in = rdw.stamp;
               best_cnt_in = rdw.count;
               best_prio_in = rdw.prio;
               best_size_in = rdw.size;
            end
            if (!pv_ff && !(sidx_ff < live)) begin
               if (found_ff) begin
                  state_in = S_EVICT;
               end else begin
                  st_in = ST_NO_ROOM;
                  state_in = S_FINAL;
               end
            end
         end
         S_EVICT: begin
            if (out_free) begin
               res_in[best_idx_ff[IDX_W-1:0]] = 1'b0;
               used_in = sub_floor(used_ff, best_size_ff);
               cnt_in = cnt_ff + 1'b1;
               rv_in = 1'b1;
               rkind_in = 1'b0;
               rentry_in = best_idx_ff;
               rst_in = ST_OK;
               rused_in = sub_floor(used_ff, best_size_ff);
               rpeak_in = peak_ff;
               rlast_in = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rv_in = 1'b1;
               rkind_in = 1'b1;
               rentry_in = (cmd_ff == CMD_BUDGET) ? '0 : layer_ff;
               rst_in = st_ff;
               rused_in = used_ff;
               rpeak_in = peak_ff;
               rlast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (wr_en) begin
         wv_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         other_ff <= req_other_layer;
      end
      rdv_ff <= wv_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff <= '0;
         wv_ff <= '0;
         strat_ff <= 2'd0;
         unl_ff <= 1'b1;
         dt_ff <= 1'b1;
         layers_ff <= 6'd32;
         budget_ff <= DEFAULT_BUDGET;
         used_ff <= '0;
         peak_ff <= '0;
         stampc_ff <= '0;
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
         found_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         res_ff <= res_in;
         wv_ff <= wv_in;
         strat_ff <= strat_in;
         unl_ff <= unl_in;
         dt_ff <= dt_in;
         layers_ff <= layers_in;
         budget_ff <= budget_in;
         used_ff <= used_in;
         peak_ff <= peak_in;
         stampc_ff <= stampc_in;
         rv_ff <= rv_in;
         pv_ff <= pv_in;
         found_ff <= found_in;
         cnt_ff <= cnt_in;
      end
      cmd_ff <= cmd_in;
      layer_ff <= layer_in;
      value_ff <= value_in;
      prio_ff <= prio_in;
      st_ff <= st_in;
      tgt_ff <= tgt_in;
      sidx_ff <= sidx_in;
      pidx_ff <= pidx_in;
      best_idx_ff <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_cnt_ff <= best_cnt_in;
      best_prio_ff <= best_prio_in;
      best_size_ff <= best_size_in;
      rkind_ff <= rkind_in;
      rentry_ff <= rentry_in;
      rst_ff <= rst_in;
      rused_ff <= rused_in;
      rpeak_ff <= rpeak_in;
      rlast_ff <= rlast_in;
   end
endmodule

>>> hw/rtl/bre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
